// ===== hdl/ssfn_pkg.sv =====
// Shared types and constants for the surface sample filter and normalizer.
package ssfn_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_MIN_SCALE    = 2'd0;
    localparam logic [1:0] REG_MAX_SCALE    = 2'd1;
    localparam logic [1:0] REG_SCALE_FACTOR = 2'd2;

    localparam logic [30:0] SCALE_FACTOR_RESET = 31'd65536;

    // Reject reason codes
    localparam logic [2:0] REASON_KEEP       = 3'd0;
    localparam logic [2:0] REASON_BAD_SCALE  = 3'd1;
    localparam logic [2:0] REASON_BAD_CONF   = 3'd2;
    localparam logic [2:0] REASON_ZERO_NORM  = 3'd3;
    localparam logic [2:0] REASON_TOO_LARGE  = 3'd4;

    // Q32.32 one and the unit-length tolerance
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] EPS_Q32 = 64'd42950;

    // Pipeline stage map
    localparam int ST_IN      = 0;
    localparam int ST_MAG     = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_NORM    = 3;
    localparam int ST_SHIFT   = 4;
    localparam int ST_SQ2     = 5;
    localparam int ST_SUM2    = 6;
    localparam int ROOT_STEPS = 32;
    localparam int ST_ROOT0   = 7;
    localparam int ST_NUM     = ST_ROOT0 + ROOT_STEPS;
    localparam int DIV_STEPS  = 17;
    localparam int ST_DIV0    = ST_NUM + 1;
    localparam int ST_OUT     = ST_DIV0 + DIV_STEPS;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic [2:0][31:0] comp;
        logic [31:0]      scale;
        logic [31:0]      conf;
        logic [2:0]       reason;
        logic             renorm;
        logic [2:0]       neg;
        logic [2:0][17:0] pass;
        logic [2:0][31:0] mag;
        logic [2:0][63:0] sqr;
        logic [63:0]      sum;
        logic [61:0]      prod;
        logic [30:0]      scale_out;
        logic [31:0]      mx;
        logic [4:0]       sh;
        logic [63:0]      op;
        logic [63:0]      res;
        logic [31:0]      root;
        logic [2:0][49:0] rem;
        logic [2:0][16:0] quo;
        logic [2:0][17:0] unit;
    } item_t;

endpackage

// ===== hdl/ssfn_if.sv =====
// Sample and result channel interfaces.
interface ssfn_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;
    logic [31:0] scale_in;
    logic [31:0] confidence_in;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output scale_in, output confidence_in, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input scale_in, input confidence_in, output ready);
endinterface

interface ssfn_result_if;
    logic        valid;
    logic        ready;
    logic        kept;
    logic [2:0]  reject_reason;
    logic        renormalized;
    logic [17:0] unit_normal_x;
    logic [17:0] unit_normal_y;
    logic [17:0] unit_normal_z;
    logic [30:0] scale_out;

    modport source (output valid, output kept, output reject_reason, output renormalized,
                    output unit_normal_x, output unit_normal_y, output unit_normal_z,
                    output scale_out, input ready);
    modport sink   (input valid, input kept, input reject_reason, input renormalized,
                    input unit_normal_x, input unit_normal_y, input unit_normal_z,
                    input scale_out, output ready);
endinterface

// ===== hdl/surface_sample_filter_normalizer.sv =====
// Surface sample filter and normalizer: reject checks, scale clamp, normal renormalization.
// Each sample passes through 58 register stages from sample transfer to result valid.
// Throughput: one sample per cycle while the result is not stalled; the 32-step square
// root and the 17-step divider are fully pipelined, one root bit and one quotient bit per stage.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the register reset values.
module surface_sample_filter_normalizer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [30:0]           cfg_data,
    ssfn_sample_if.sink           sample,
    ssfn_result_if.source         result
);

    logic [30:0] min_scale_reg;
    logic [30:0] max_scale_reg;
    logic [30:0] scale_factor_reg;

    logic [ssfn_pkg::NUM_STAGES-1:0] vld_reg;
    ssfn_pkg::item_t pipe_reg  [ssfn_pkg::NUM_STAGES];
    ssfn_pkg::item_t pipe_next [ssfn_pkg::NUM_STAGES];
    logic            adv;

    assign adv          = !vld_reg[ssfn_pkg::ST_OUT] || result.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_scale_reg    <= '0;
            max_scale_reg    <= '0;
            scale_factor_reg <= ssfn_pkg::SCALE_FACTOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssfn_pkg::REG_MIN_SCALE:    min_scale_reg    <= cfg_data;
                ssfn_pkg::REG_MAX_SCALE:    max_scale_reg    <= cfg_data;
                ssfn_pkg::REG_SCALE_FACTOR: scale_factor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[ssfn_pkg::NUM_STAGES-2:0], sample.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < ssfn_pkg::NUM_STAGES; i++)
                pipe_reg[i] <= pipe_next[i];
        end
    end

    // Capture the transfer
    always_comb
    begin
        pipe_next[ssfn_pkg::ST_IN]       = '0;
        pipe_next[ssfn_pkg::ST_IN].comp  = {sample.normal_z, sample.normal_y, sample.normal_x};
        pipe_next[ssfn_pkg::ST_IN].scale = sample.scale_in;
        pipe_next[ssfn_pkg::ST_IN].conf  = sample.confidence_in;
    end

    // Magnitudes, squares, reject checks, clamped scale product
    always_comb
    begin
        ssfn_pkg::item_t it;
        logic [30:0]     s;
        it = pipe_reg[ssfn_pkg::ST_IN];
        for (int i = 0; i < 3; i++)
        begin
            it.neg[i]  = it.comp[i][31];
            it.pass[i] = it.comp[i][17:0];
            it.mag[i]  = it.comp[i][31] ? (~it.comp[i] + 32'd1) : it.comp[i];
            it.sqr[i]  = it.mag[i] * it.mag[i];
        end
        if (it.scale[31] || it.scale == '0)
            it.reason = ssfn_pkg::REASON_BAD_SCALE;
        else if (it.conf[31] || it.conf == '0)
            it.reason = ssfn_pkg::REASON_BAD_CONF;
        else if (it.comp == '0)
            it.reason = ssfn_pkg::REASON_ZERO_NORM;
        else if (max_scale_reg != '0 && it.scale[30:0] > max_scale_reg)
            it.reason = ssfn_pkg::REASON_TOO_LARGE;
        else
            it.reason = ssfn_pkg::REASON_KEEP;
        s = it.scale[30:0];
        if (min_scale_reg != '0 && s < min_scale_reg)
            s = min_scale_reg;
        it.prod = s * scale_factor_reg;
        pipe_next[ssfn_pkg::ST_MAG] = it;
    end

    // Squared length, rounded and saturated scale, largest magnitude
    always_comb
    begin
        ssfn_pkg::item_t it;
        logic [62:0]     rnd;
        it  = pipe_reg[ssfn_pkg::ST_MAG];
        it.sum = it.sqr[0] + it.sqr[1] + it.sqr[2];
        rnd = {1'b0, it.prod} + 63'd32768;
        it.scale_out = (rnd[62:47] != '0) ? '1 : rnd[46:16];
        it.mx = it.mag[0];
        if (it.mag[1] > it.mx)
            it.mx = it.mag[1];
        if (it.mag[2] > it.mx)
            it.mx = it.mag[2];
        pipe_next[ssfn_pkg::ST_SUM] = it;
    end

    // Tolerance test and normalizing shift count
    always_comb
    begin
        ssfn_pkg::item_t it;
        logic [63:0]     diff;
        it   = pipe_reg[ssfn_pkg::ST_SUM];
        diff = (it.sum > ssfn_pkg::ONE_Q32) ? it.sum - ssfn_pkg::ONE_Q32
                                            : ssfn_pkg::ONE_Q32 - it.sum;
        it.renorm = (diff > ssfn_pkg::EPS_Q32);
        it.sh = '0;
        // Shift until the largest magnitude reaches bit 30
        for (int b = 0; b < 30; b++)
        begin
            if (it.mx[b])
                it.sh = 5'(30 - b);
        end
        if (it.mx[31] || it.mx[30])
            it.sh = '0;
        pipe_next[ssfn_pkg::ST_NORM] = it;
    end

    always_comb
    begin
        ssfn_pkg::item_t it;
        it = pipe_reg[ssfn_pkg::ST_NORM];
        for (int i = 0; i < 3; i++)
            it.mag[i] = it.mag[i] << it.sh;
        pipe_next[ssfn_pkg::ST_SHIFT] = it;
    end

    always_comb
    begin
        ssfn_pkg::item_t it;
        it = pipe_reg[ssfn_pkg::ST_SHIFT];
        for (int i = 0; i < 3; i++)
            it.sqr[i] = it.mag[i] * it.mag[i];
        pipe_next[ssfn_pkg::ST_SQ2] = it;
    end

    // Seed the root with the normalized squared length
    always_comb
    begin
        ssfn_pkg::item_t it;
        it     = pipe_reg[ssfn_pkg::ST_SQ2];
        it.op  = it.sqr[0] + it.sqr[1] + it.sqr[2];
        it.res = '0;
        pipe_next[ssfn_pkg::ST_SUM2] = it;
    end

    // Integer square root, one result bit per stage
    for (genvar k = 0; k < ssfn_pkg::ROOT_STEPS; k++)
    begin : g_root
        localparam int BP = 62 - 2 * k;
        always_comb
        begin
            ssfn_pkg::item_t it;
            logic [63:0]     rbit;
            logic [63:0]     trial;
            it    = pipe_reg[ssfn_pkg::ST_ROOT0 + k - 1];
            rbit  = 64'd1 << BP;
            trial = it.res + rbit;
            if (it.op >= trial)
            begin
                it.op  = it.op - trial;
                it.res = (it.res >> 1) + rbit;
            end
            else
            begin
                it.res = it.res >> 1;
            end
            pipe_next[ssfn_pkg::ST_ROOT0 + k] = it;
        end
    end

    // Dividend with half the divisor added for round half up
    always_comb
    begin
        ssfn_pkg::item_t it;
        it      = pipe_reg[ssfn_pkg::ST_NUM - 1];
        it.root = it.res[31:0];
        for (int i = 0; i < 3; i++)
        begin
            it.rem[i] = ({18'd0, it.mag[i]} << 16) + {19'd0, it.root[31:1]};
            it.quo[i] = '0;
        end
        pipe_next[ssfn_pkg::ST_NUM] = it;
    end

    // Restoring divide, one quotient bit per stage, three lanes
    for (genvar j = 0; j < ssfn_pkg::DIV_STEPS; j++)
    begin : g_div
        localparam int QB = ssfn_pkg::DIV_STEPS - 1 - j;
        always_comb
        begin
            ssfn_pkg::item_t it;
            logic [49:0]     dsr;
            it  = pipe_reg[ssfn_pkg::ST_DIV0 + j - 1];
            dsr = {18'd0, it.root} << QB;
            for (int i = 0; i < 3; i++)
            begin
                if (it.rem[i] >= dsr)
                begin
                    it.rem[i]     = it.rem[i] - dsr;
                    it.quo[i][QB] = 1'b1;
                end
            end
            pipe_next[ssfn_pkg::ST_DIV0 + j] = it;
        end
    end

    // Apply signs, pick pass-through or rescaled normal, clear rejects
    always_comb
    begin
        ssfn_pkg::item_t it;
        logic [17:0]     q;
        it = pipe_reg[ssfn_pkg::ST_OUT - 1];
        for (int i = 0; i < 3; i++)
        begin
            q = {1'b0, it.quo[i]};
            if (it.reason != ssfn_pkg::REASON_KEEP)
                it.unit[i] = '0;
            else if (it.renorm)
                it.unit[i] = it.neg[i] ? (~q + 18'd1) : q;
            else
                it.unit[i] = it.pass[i];
        end
        if (it.reason != ssfn_pkg::REASON_KEEP)
        begin
            it.renorm    = 1'b0;
            it.scale_out = '0;
        end
        pipe_next[ssfn_pkg::ST_OUT] = it;
    end

    assign result.valid         = vld_reg[ssfn_pkg::ST_OUT];
    assign result.kept          = (pipe_reg[ssfn_pkg::ST_OUT].reason == ssfn_pkg::REASON_KEEP);
    assign result.reject_reason = pipe_reg[ssfn_pkg::ST_OUT].reason;
    assign result.renormalized  = pipe_reg[ssfn_pkg::ST_OUT].renorm;
    assign result.unit_normal_x = pipe_reg[ssfn_pkg::ST_OUT].unit[0];
    assign result.unit_normal_y = pipe_reg[ssfn_pkg::ST_OUT].unit[1];
    assign result.unit_normal_z = pipe_reg[ssfn_pkg::ST_OUT].unit[2];
    assign result.scale_out     = pipe_reg[ssfn_pkg::ST_OUT].scale_out;

    // A stalled result blocks new transfers
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !sample.ready)
        else $error("sample accepted while result stalled");

    a_reject_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.kept) |->
            (!result.renormalized && result.scale_out == '0 &&
             result.unit_normal_x == '0 && result.unit_normal_y == '0 &&
             result.unit_normal_z == '0))
        else $error("rejected sample carries payload");

    a_renorm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.renormalized) |->
            (result.unit_normal_x != 18'h20000 && result.unit_normal_y != 18'h20000 &&
             result.unit_normal_z != 18'h20000))
        else $error("renormalized component out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        $past(result.valid && !result.ready) |-> result.valid)
        else $error("stalled result lost");

endmodule
